@@ rtl/core/utf8sd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_pkg: shared types and constants of the UTF-8 stream decoder
// Request and result payloads, decoder state and lead byte code ranges.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

	localparam int unsigned CP_W  = 31;
	localparam int unsigned REM_W = 3;

	// Lead byte ranges, longest form first
	localparam logic [7:0] LEAD6_MIN = 8'hFC;
	localparam logic [7:0] LEAD5_MIN = 8'hF8;
	localparam logic [7:0] LEAD5_MAX = 8'hFB;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD2_MIN = 8'hC0;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] BYTE_MAX  = 8'hFF;

	// Continuation bytes still expected after each lead form
	localparam logic [REM_W-1:0] REM_LEAD6 = 3'd5;
	localparam logic [REM_W-1:0] REM_LEAD5 = 3'd4;
	localparam logic [REM_W-1:0] REM_LEAD4 = 3'd3;
	localparam logic [REM_W-1:0] REM_LEAD3 = 3'd2;
	localparam logic [REM_W-1:0] REM_LEAD2 = 3'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} stream_req_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            at_end;
	} code_rsp_t;

	typedef struct packed {
		logic [CP_W-1:0]  accumulator;
		logic [REM_W-1:0] bytes_remaining;
	} dec_state_t;

endpackage

@@ rtl/core/utf8sd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_decode: next-state and result logic for one byte
// Classifies the byte, updates accumulator and count, flags a finished value.
// ----------------------------------------------------------------------------
module utf8sd_decode (
	input  utf8sd_pkg::dec_state_t  cur,
	input  utf8sd_pkg::stream_req_t req,
	output utf8sd_pkg::dec_state_t  nxt,
	output logic                    emit,
	output utf8sd_pkg::code_rsp_t   rsp
);
	import utf8sd_pkg::*;

	logic [7:0]       b;
	logic             lead;
	logic [CP_W-1:0]  lead_acc;
	logic [REM_W-1:0] lead_rem;
	logic [CP_W-1:0]  acc_w;
	logic [REM_W-1:0] rem_w;
	logic [CP_W-7:0]  base;

	assign b = req.data_byte;

	always_comb begin
		lead     = 1'b1;
		lead_acc = '0;
		lead_rem = '0;
		case (b) inside
			[LEAD6_MIN:BYTE_MAX]: begin
				lead_acc = {{(CP_W-1){1'b0}}, b[0]};
				lead_rem = REM_LEAD6;
			end
			[LEAD5_MIN:LEAD5_MAX]: begin
				lead_acc = {{(CP_W-2){1'b0}}, b[1:0]};
				lead_rem = REM_LEAD5;
			end
			[LEAD4_MIN:LEAD4_MAX]: begin
				lead_acc = {{(CP_W-3){1'b0}}, b[2:0]};
				lead_rem = REM_LEAD4;
			end
			[LEAD3_MIN:LEAD3_MAX]: begin
				lead_acc = {{(CP_W-4){1'b0}}, b[3:0]};
				lead_rem = REM_LEAD3;
			end
			[LEAD2_MIN:LEAD2_MAX]: begin
				lead_acc = {{(CP_W-5){1'b0}}, b[4:0]};
				lead_rem = REM_LEAD2;
			end
			default: begin
				lead = 1'b0;
			end
		endcase
	end

	always_comb begin
		// a continuation with no open sequence shifts onto zero
		base  = (cur.bytes_remaining == '0) ? '0 : cur.accumulator[CP_W-7:0];
		acc_w = b[7] ? {base, b[5:0]} : {{(CP_W-8){1'b0}}, b};
		rem_w = (cur.bytes_remaining == '0) ? '0 : cur.bytes_remaining - 1'b1;

		nxt  = cur;
		emit = 1'b0;
		rsp  = '0;
		if (req.end_of_input) begin
			nxt        = '0;
			emit       = 1'b1;
			rsp.at_end = 1'b1;
		end else if (lead) begin
			nxt.accumulator     = lead_acc;
			nxt.bytes_remaining = lead_rem;
		end else begin
			nxt.bytes_remaining = rem_w;
			if (rem_w == '0) begin
				emit            = 1'b1;
				rsp.code_point  = acc_w;
				nxt.accumulator = '0;
			end else begin
				nxt.accumulator = acc_w;
			end
		end
	end

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder: permissive byte-serial UTF-8 decoder
//
// Input channel stream (stream_valid / stream_stall / stream): one request per
// byte, or an end-of-input request that drops any partial sequence.
// Output channel code (code_valid / code_stall / code): one code point per
// finished sequence, or an end marker (at_end set, code_point zero).
// A taken request passes through the request register, then the result register.
// Throughput: one request per cycle while stream_stall is low; the accumulator
// update is a single mask, shift and count step between the request register
// and the result register.
// Reset (arst_n low) empties both registers and clears the decoder state to
// idle with a zero accumulator.
// When code_stall holds a result, requests that finish nothing keep flowing;
// the next request that finishes a value waits in the request register and
// stream_stall rises until the result register frees.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    stream_valid,
	output logic                    stream_stall,
	input  utf8sd_pkg::stream_req_t stream,
	output logic                    code_valid,
	input  logic                    code_stall,
	output utf8sd_pkg::code_rsp_t   code
);
	import utf8sd_pkg::*;

	logic        valid_s1;
	stream_req_t req_s1;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	logic        emit;
	code_rsp_t   rsp;
	logic        out_valid_q;
	code_rsp_t   out_q;
	logic        advance;
	logic        accept;

	utf8sd_decode u_decode (
		.cur  (state_q),
		.req  (req_s1),
		.nxt  (state_nxt),
		.emit (emit),
		.rsp  (rsp)
	);

	// advance unless a result must wait behind a held one
	assign advance      = valid_s1 && (!emit || !out_valid_q || !code_stall);
	assign stream_stall = valid_s1 && !advance;
	assign accept       = stream_valid && !stream_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= accept || stream_stall;
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (!code_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= stream;
		end
		if (advance && emit) begin
			out_q <= rsp;
		end
	end

	assign code_valid = out_valid_q;
	assign code       = out_q;

endmodule
